// ===== rtl/core/drq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drq_pkg: shared types and constants of the deadline run queue scheduler
// Task and time widths, operation codes, sequencer states and the queue
// command word.
// ----------------------------------------------------------------------------
package drq_pkg;

   localparam int NUM_TASKS       = 16;
   localparam int TASK_BITS       = 4;
   localparam int CNT_BITS        = 5;
   localparam int TIME_BITS       = 48;
   localparam int SLICE_BITS      = 18;
   localparam int TICK_BITS       = 16;
   localparam int FACTOR_BITS     = 7;
   localparam int ELAPSED_BITS    = 24;
   localparam int ACT_BITS        = 2;
   localparam int CSR_IDX_BITS    = 1;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [TICK_BITS-1:0]   SLICE_TICKS_RESET = 16'd10000;
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET      = 7'd8;
   localparam logic [SLICE_BITS-1:0]  SLICE_MIN         = 18'h20000;

   // Input word actions.
   localparam logic [ACT_BITS-1:0] ACT_SCHEDULE = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_YIELD    = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_CHECK    = 2'd2;
   localparam logic [ACT_BITS-1:0] ACT_CLEAR    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLICE_TICKS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FACTOR      = 1'd1;

   typedef enum logic [1:0] {
      ALU_ADD_SAT,
      ALU_MUL,
      ALU_LT
   } alu_op_type;

   typedef enum logic [1:0] {
      Q_NONE,
      Q_PUSH_BACK,
      Q_PUSH_FRONT,
      Q_REMOVE
   } q_op_type;

   typedef struct packed {
      q_op_type             op;
      logic [TASK_BITS-1:0] idx;
      logic [TASK_BITS-1:0] id;
   } q_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CK_TEST,
      ST_Y_START,
      ST_Y_LOAD0,
      ST_Y_SCAN,
      ST_Y_STOP,
      ST_Y_PICK,
      ST_Y_F1,
      ST_Y_F2,
      ST_Y_END,
      ST_SCH_START,
      ST_SCH_FIND,
      ST_SCH_REFILL,
      ST_SCH_DL,
      ST_SCH_RUN,
      ST_SCH_U1,
      ST_SCH_U2,
      ST_CLR_FIND,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/drq_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drq_alu: shared arithmetic unit
// One saturating time adder, one slice by factor multiplier and one magnitude
// compare, used by the sequencer one operation per cycle.
// ----------------------------------------------------------------------------
module drq_alu import drq_pkg::*; (
   input  alu_op_type           op,
   input  logic [TIME_BITS-1:0] a,
   input  logic [TIME_BITS-1:0] b,
   output logic [TIME_BITS-1:0] res,
   output logic                 lt
);

   logic [TIME_BITS:0]                   sum;
   logic [TICK_BITS+FACTOR_BITS-1:0]     prod;

   assign sum  = {1'b0, a} + {1'b0, b};
   assign prod = a[TICK_BITS-1:0] * b[FACTOR_BITS-1:0];
   assign lt   = (a < b);

   // Result select; time sums clamp at the all-ones value.
   always_comb begin
      unique case (op)
         ALU_ADD_SAT: res = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
         ALU_MUL:     res = TIME_BITS'(prod);
         default:     res = '0;
      endcase
   end

endmodule

// ===== rtl/core/drq_run_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drq_run_queue: FIFO run queue of task numbers
// Ordered list with append, insert at head and removal at any position, each
// registered, and one read port at a chosen position.
// ----------------------------------------------------------------------------
module drq_run_queue import drq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  q_cmd_type            cmd,
   input  logic [TASK_BITS-1:0] rd_idx,
   output logic [TASK_BITS-1:0] rd_id,
   output logic [CNT_BITS-1:0]  count
);

   logic [TASK_BITS-1:0] q_ff [NUM_TASKS];
   logic [TASK_BITS-1:0] q_in [NUM_TASKS];
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic                 full;

   assign full  = (count_ff >= CNT_BITS'(NUM_TASKS));
   assign rd_id = q_ff[rd_idx];
   assign count = count_ff;

   // Next contents: every entry looks at its own neighbors and the command word only.
   always_comb begin
      q_in     = q_ff;
      count_in = count_ff;
      unique case (cmd.op)
         Q_PUSH_BACK: begin
            if (!full) begin
               q_in[count_ff[TASK_BITS-1:0]] = cmd.id;
               count_in = count_ff + 1'b1;
            end
         end
         Q_PUSH_FRONT: begin
            if (!full) begin
               for (int j = 1; j < NUM_TASKS; j++) begin
                  q_in[j] = q_ff[j-1];
               end
               q_in[0]  = cmd.id;
               count_in = count_ff + 1'b1;
            end
         end
         Q_REMOVE: begin
            if ({1'b0, cmd.idx} < count_ff) begin
               for (int j = 0; j < NUM_TASKS - 1; j++) begin
                  if (TASK_BITS'(j) >= cmd.idx) begin
                     q_in[j] = q_ff[j+1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // The fill count stays within the queue depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(NUM_TASKS))
      else $error("run queue count beyond depth");

   // A removal inside the list shortens it by one.
   a_remove: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == Q_REMOVE && {1'b0, cmd.idx} < count_ff) |=>
      count_ff == $past(count_ff) - 1'b1)
      else $error("run queue removal did not shorten the list");

   // An insertion at the head into a list with room lands the word at entry 0.
   a_push_front: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == Q_PUSH_FRONT && !full) |=>
      (q_ff[0] == $past(cmd.id) && count_ff == $past(count_ff) + 1'b1))
      else $error("run queue head insertion lost");

endmodule

// ===== rtl/core/deadline_run_queue_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_run_queue_scheduler_top: earliest deadline first task scheduler
// Sequencer, task tables and state around one shared arithmetic unit and the
// run queue.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and answers each with one result
// word: a schedule request scans the run queue for the task one entry per cycle
// (up to 16) and then goes on to refill and deadline compares; a yield scans
// the queued deadlines one per cycle through the shared compare unit, with an
// extra step each time a new earliest deadline is found, plus bookkeeping. A
// checkpoint that yields runs both. req_stall is high from acceptance until the
// result word is placed in the output register, which holds it until taken.
// Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module deadline_run_queue_scheduler_top import drq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ACT_BITS-1:0]      req_action,
   input  logic [TASK_BITS-1:0]     req_task_id,
   input  logic [ELAPSED_BITS-1:0]  req_elapsed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [TASK_BITS-1:0]     rsp_run_task,
   output logic                     rsp_run_valid,
   output logic                     rsp_queued,
   output logic                     rsp_force_switch,
   output logic                     rsp_preempt_flag,
   output logic                     rsp_check_flag,
   output logic                     rsp_switched,
   output logic [CNT_BITS-1:0]      rsp_waiting_count,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   // Sequencer and configuration.
   state_type                state_ff, state_in;
   logic [TICK_BITS-1:0]     slice_ticks_ff;
   logic [FACTOR_BITS-1:0]   factor_ff;

   // Task tables.
   logic [SLICE_BITS-1:0]    slice_ff [NUM_TASKS];
   logic [TIME_BITS-1:0]     dl_ff    [NUM_TASKS];
   logic                     slice_we, dl_we;
   logic [SLICE_BITS-1:0]    slice_wdata;
   logic [TIME_BITS-1:0]     dl_wdata;

   // Scheduler state.
   logic [TIME_BITS-1:0]     vt_ff, vt_in;
   logic [TASK_BITS-1:0]     run_id_ff, run_id_in;
   logic                     run_v_ff, run_v_in;
   logic [TASK_BITS-1:0]     prev_id_ff, prev_id_in;
   logic                     prev_v_ff, prev_v_in;
   logic                     opaque_ff, opaque_in;
   logic                     pre_ff, pre_in;
   logic                     chk_ff, chk_in;
   logic                     swp_ff, swp_in;
   logic [TASK_BITS-1:0]     swid_ff, swid_in;

   // Per-word working registers.
   logic [ACT_BITS-1:0]      act_ff, act_in;
   logic [TASK_BITS-1:0]     tid_ff, tid_in;
   logic [ELAPSED_BITS-1:0]  elap_ff, elap_in;
   logic [TICK_BITS-1:0]     iv_ff, iv_in;
   logic                     queued_ff, queued_in;
   logic                     force_ff, force_in;
   logic                     switched_ff, switched_in;
   logic                     fast_ff, fast_in;
   logic [CNT_BITS-1:0]      scan_ff, scan_in;
   logic [TASK_BITS-1:0]     best_ff, best_in;
   logic [TIME_BITS-1:0]     bestdl_ff, bestdl_in;
   logic                     stop_ff, stop_in;
   logic [TIME_BITS-1:0]     tmp_ff, tmp_in;

   // Result word register.
   logic                     rsp_v_ff, rsp_v_in;
   logic [TASK_BITS-1:0]     o_task_ff, o_task_in;
   logic                     o_runv_ff, o_runv_in;
   logic                     o_queued_ff, o_queued_in;
   logic                     o_force_ff, o_force_in;
   logic                     o_pre_ff, o_pre_in;
   logic                     o_chk_ff, o_chk_in;
   logic                     o_sw_ff, o_sw_in;
   logic [CNT_BITS-1:0]      o_cnt_ff, o_cnt_in;

   // Shared unit and queue hookup.
   alu_op_type               alu_op;
   logic [TIME_BITS-1:0]     alu_a, alu_b, alu_res;
   logic                     alu_lt;
   q_cmd_type                q_cmd;
   logic [TASK_BITS-1:0]     q_rd_idx, q_rd_id;
   logic [CNT_BITS-1:0]      q_count;

   // Derived conditions.
   logic [TASK_BITS-1:0]     dl_addr;
   logic [TIME_BITS-1:0]     dl_rd;
   logic [SLICE_BITS-1:0]    slice_t;
   logic                     slice_depleted, slice_le_iv;
   logic [SLICE_BITS:0]      slice_sub;
   logic [SLICE_BITS-1:0]    slice_charged;
   logic                     holder, accept, scan_end, q_match, out_free;

   drq_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res),
      .lt  (alu_lt)
   );

   drq_run_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (q_cmd),
      .rd_idx (q_rd_idx),
      .rd_id  (q_rd_id),
      .count  (q_count)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign holder    = run_v_ff && (run_id_ff == tid_ff);
   assign scan_end  = (scan_ff >= q_count);
   assign q_match   = (q_rd_id == tid_ff);

   // Slice of the current task and its charged, clamped value.
   assign slice_t        = slice_ff[tid_ff];
   assign slice_depleted = slice_t[SLICE_BITS-1] || (slice_t == '0);
   assign slice_le_iv    = $signed({slice_t[SLICE_BITS-1], slice_t}) <=
                           $signed({{(SLICE_BITS+1-TICK_BITS){1'b0}}, iv_ff});
   assign slice_sub      = {slice_t[SLICE_BITS-1], slice_t} -
                           {{(SLICE_BITS+1-TICK_BITS){1'b0}}, iv_ff};
   assign slice_charged  = (slice_sub[SLICE_BITS] && !slice_sub[SLICE_BITS-1]) ?
                           SLICE_MIN : slice_sub[SLICE_BITS-1:0];

   // Queue read position.
   always_comb begin
      unique case (state_ff)
         ST_Y_LOAD0: q_rd_idx = '0;
         ST_Y_PICK:  q_rd_idx = best_ff;
         default:    q_rd_idx = scan_ff[TASK_BITS-1:0];
      endcase
   end

   // Deadline table read address, one per cycle.
   always_comb begin
      unique case (state_ff)
         ST_Y_LOAD0, ST_Y_SCAN: dl_addr = q_rd_id;
         ST_SCH_U1, ST_SCH_U2:  dl_addr = run_id_ff;
         default:               dl_addr = tid_ff;
      endcase
   end
   assign dl_rd = dl_ff[dl_addr];

   // Operands of the shared unit.
   always_comb begin
      alu_op = ALU_LT;
      alu_a  = '0;
      alu_b  = '0;
      unique case (state_ff)
         ST_DISPATCH: begin
            alu_a = TIME_BITS'(elap_ff);
            alu_b = TIME_BITS'(slice_ticks_ff);
         end
         ST_Y_START: begin
            alu_op = ALU_ADD_SAT;
            alu_a  = vt_ff;
            alu_b  = TIME_BITS'(iv_ff);
         end
         ST_Y_LOAD0: begin
            alu_a = vt_ff;
            alu_b = dl_rd;
         end
         ST_Y_SCAN: begin
            alu_a = dl_rd;
            alu_b = bestdl_ff;
         end
         ST_Y_STOP: begin
            alu_a = vt_ff;
            alu_b = bestdl_ff;
         end
         ST_Y_F1: begin
            alu_a = bestdl_ff;
            alu_b = vt_ff;
         end
         ST_Y_F2: begin
            alu_a = dl_rd;
            alu_b = bestdl_ff;
         end
         ST_SCH_REFILL: begin
            alu_op = ALU_MUL;
            alu_a  = TIME_BITS'(slice_ticks_ff);
            alu_b  = TIME_BITS'(factor_ff);
         end
         ST_SCH_DL: begin
            alu_op = ALU_ADD_SAT;
            alu_a  = vt_ff;
            alu_b  = tmp_ff;
         end
         ST_SCH_U1: begin
            alu_a = dl_rd;
            alu_b = tmp_ff;
         end
         ST_SCH_U2: begin
            alu_a = dl_rd;
            alu_b = vt_ff;
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (act_ff)
               ACT_SCHEDULE: state_in = ST_SCH_START;
               ACT_YIELD:    state_in = (run_v_ff && (holder || opaque_ff)) ?
                                        ST_Y_START : ST_DONE;
               ACT_CHECK:    state_in = holder ? ST_CK_TEST : ST_DONE;
               default:      state_in = ST_CLR_FIND;
            endcase
         end
         ST_CK_TEST:  state_in = (pre_ff || slice_le_iv) ? ST_Y_START : ST_DONE;
         ST_Y_START:  state_in = (q_count == '0) ? ST_Y_END : ST_Y_LOAD0;
         ST_Y_LOAD0:  state_in = ST_Y_SCAN;
         ST_Y_SCAN: begin
            priority if (scan_end || stop_ff) state_in = ST_Y_PICK;
            else if (alu_lt)                  state_in = ST_Y_STOP;
            else                              state_in = ST_Y_SCAN;
         end
         ST_Y_STOP:   state_in = ST_Y_SCAN;
         ST_Y_PICK:   state_in = (opaque_ff || slice_depleted) ? ST_Y_END : ST_Y_F1;
         ST_Y_F1:     state_in = alu_lt ? ST_Y_END : ST_Y_F2;
         ST_Y_F2:     state_in = ST_Y_END;
         ST_Y_END:    state_in = (act_ff == ACT_CHECK) ? ST_SCH_START : ST_DONE;
         ST_SCH_START: state_in = holder ? ST_DONE : ST_SCH_FIND;
         ST_SCH_FIND: begin
            priority if (scan_end) state_in = ST_SCH_REFILL;
            else if (q_match)      state_in = ST_DONE;
            else                   state_in = ST_SCH_FIND;
         end
         ST_SCH_REFILL: state_in = slice_depleted ? ST_SCH_DL : ST_SCH_RUN;
         ST_SCH_DL:     state_in = ST_SCH_RUN;
         ST_SCH_RUN:    state_in = (!run_v_ff || opaque_ff) ? ST_DONE : ST_SCH_U1;
         ST_SCH_U1:     state_in = alu_lt ? ST_DONE : ST_SCH_U2;
         ST_SCH_U2:     state_in = ST_DONE;
         ST_CLR_FIND:   state_in = (scan_end || q_match) ? ST_DONE : ST_CLR_FIND;
         ST_DONE:       if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath updates of each sequencer step.
   always_comb begin
      vt_in       = vt_ff;
      run_id_in   = run_id_ff;
      run_v_in    = run_v_ff;
      prev_id_in  = prev_id_ff;
      prev_v_in   = prev_v_ff;
      opaque_in   = opaque_ff;
      pre_in      = pre_ff;
      chk_in      = chk_ff;
      swp_in      = swp_ff;
      swid_in     = swid_ff;
      act_in      = act_ff;
      tid_in      = tid_ff;
      elap_in     = elap_ff;
      iv_in       = iv_ff;
      queued_in   = queued_ff;
      force_in    = force_ff;
      switched_in = switched_ff;
      fast_in     = fast_ff;
      scan_in     = scan_ff;
      best_in     = best_ff;
      bestdl_in   = bestdl_ff;
      stop_in     = stop_ff;
      tmp_in      = tmp_ff;
      slice_we    = 1'b0;
      slice_wdata = slice_charged;
      dl_we       = 1'b0;
      dl_wdata    = alu_res;
      q_cmd.op    = Q_NONE;
      q_cmd.idx   = scan_ff[TASK_BITS-1:0];
      q_cmd.id    = tid_ff;
      rsp_v_in    = rsp_v_ff && rsp_stall;
      o_task_in   = o_task_ff;
      o_runv_in   = o_runv_ff;
      o_queued_in = o_queued_ff;
      o_force_in  = o_force_ff;
      o_pre_in    = o_pre_ff;
      o_chk_in    = o_chk_ff;
      o_sw_in     = o_sw_ff;
      o_cnt_in    = o_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               tid_in  = req_task_id;
               elap_in = req_elapsed;
            end
         end
         ST_DISPATCH: begin
            iv_in       = alu_lt ? elap_ff[TICK_BITS-1:0] : slice_ticks_ff;
            queued_in   = 1'b0;
            force_in    = 1'b0;
            switched_in = 1'b0;
            fast_in     = 1'b0;
            scan_in     = '0;
            unique case (act_ff)
               ACT_YIELD: fast_in = 1'b1;
               ACT_CHECK: begin
                  if (holder) begin
                     prev_v_in = 1'b0;
                     swp_in    = 1'b0;
                     chk_in    = 1'b0;
                  end
               end
               ACT_CLEAR: begin
                  if (holder) begin
                     opaque_in = 1'b1;
                  end else if (prev_v_ff && prev_id_ff == tid_ff) begin
                     prev_v_in = 1'b0;
                  end
                  if (swp_ff && swid_ff == tid_ff) begin
                     swp_in = 1'b0;
                  end
                  slice_we    = 1'b1;
                  slice_wdata = '0;
                  dl_we       = 1'b1;
                  dl_wdata    = '0;
               end
               default: ;
            endcase
         end
         ST_CK_TEST: begin
            if (pre_ff || slice_le_iv) switched_in = 1'b1;
         end
         ST_Y_START: begin
            if (!opaque_ff) begin
               vt_in    = alu_res;
               slice_we = 1'b1;
            end
            pre_in    = 1'b0;
            chk_in    = 1'b0;
            prev_v_in = 1'b0;
            swp_in    = 1'b0;
            if (!opaque_ff && fast_ff) begin
               prev_id_in = tid_ff;
               prev_v_in  = 1'b1;
            end
            if (q_count == '0) begin
               run_v_in  = 1'b0;
               run_id_in = '0;
            end
            scan_in = CNT_BITS'(1);
            best_in = '0;
         end
         ST_Y_LOAD0: begin
            bestdl_in = dl_rd;
            stop_in   = !alu_lt;
         end
         ST_Y_SCAN: begin
            if (!(scan_end || stop_ff)) begin
               scan_in = scan_ff + 1'b1;
               if (alu_lt) begin
                  best_in   = scan_ff[TASK_BITS-1:0];
                  bestdl_in = dl_rd;
               end
            end
         end
         ST_Y_STOP: stop_in = !alu_lt;
         ST_Y_PICK: begin
            q_cmd.op  = Q_REMOVE;
            q_cmd.idx = best_ff;
            run_id_in = q_rd_id;
            run_v_in  = 1'b1;
            if (!opaque_ff && slice_depleted) begin
               force_in = 1'b1;
               swp_in   = 1'b1;
               swid_in  = tid_ff;
            end
         end
         ST_Y_F1: begin
            if (alu_lt) begin
               force_in = 1'b1;
               swp_in   = 1'b1;
               swid_in  = tid_ff;
            end
         end
         ST_Y_F2: begin
            if (!alu_lt) begin
               force_in = 1'b1;
               swp_in   = 1'b1;
               swid_in  = tid_ff;
            end
         end
         ST_Y_END: opaque_in = 1'b0;
         ST_SCH_START: begin
            if (holder) begin
               prev_v_in = 1'b0;
               swp_in    = 1'b0;
            end
            scan_in = '0;
         end
         ST_SCH_FIND: begin
            if (!scan_end) scan_in = scan_ff + 1'b1;
         end
         ST_SCH_REFILL: begin
            tmp_in = alu_res;
            if (slice_depleted) begin
               slice_we    = 1'b1;
               slice_wdata = SLICE_BITS'(slice_ticks_ff);
            end
         end
         ST_SCH_DL: dl_we = 1'b1;
         ST_SCH_RUN: begin
            priority if (!run_v_ff) begin
               run_id_in = tid_ff;
               run_v_in  = 1'b1;
               prev_v_in = 1'b0;
               swp_in    = 1'b0;
            end else if (opaque_ff) begin
               chk_in    = 1'b1;
               q_cmd.op  = Q_PUSH_BACK;
               queued_in = 1'b1;
            end else begin
               tmp_in = dl_rd;
            end
         end
         ST_SCH_U1: begin
            if (alu_lt) begin
               chk_in    = 1'b1;
               q_cmd.op  = Q_PUSH_BACK;
               queued_in = 1'b1;
            end
         end
         ST_SCH_U2: begin
            priority if (alu_lt) begin
               chk_in    = 1'b1;
               q_cmd.op  = Q_PUSH_BACK;
               queued_in = 1'b1;
            end else if (prev_v_ff) begin
               // Snatch: the displaced grantee goes back to the queue head.
               q_cmd.op  = Q_PUSH_FRONT;
               q_cmd.id  = run_id_ff;
               run_id_in = tid_ff;
               prev_v_in = 1'b0;
               swp_in    = 1'b0;
            end else begin
               pre_in    = 1'b1;
               q_cmd.op  = Q_PUSH_BACK;
               queued_in = 1'b1;
            end
         end
         ST_CLR_FIND: begin
            if (!scan_end) begin
               scan_in = scan_ff + 1'b1;
               if (q_match) q_cmd.op = Q_REMOVE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               o_task_in   = run_v_ff ? run_id_ff : '0;
               o_runv_in   = run_v_ff;
               o_queued_in = queued_ff;
               o_force_in  = force_ff;
               o_pre_in    = pre_ff;
               o_chk_in    = chk_ff;
               o_sw_in     = switched_ff;
               o_cnt_in    = q_count;
            end
         end
         default: ;
      endcase
   end

   // Task tables, written only at the current task.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            slice_ff[i] <= '0;
            dl_ff[i]    <= '0;
         end
      end else begin
         if (slice_we) slice_ff[tid_ff] <= slice_wdata;
         if (dl_we)    dl_ff[tid_ff]    <= dl_wdata;
      end
   end

   // Control and scheduler state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slice_ticks_ff <= SLICE_TICKS_RESET;
         factor_ff      <= FACTOR_RESET;
         vt_ff          <= '0;
         run_id_ff      <= '0;
         run_v_ff       <= 1'b0;
         prev_id_ff     <= '0;
         prev_v_ff      <= 1'b0;
         opaque_ff      <= 1'b0;
         pre_ff         <= 1'b0;
         chk_ff         <= 1'b0;
         swp_ff         <= 1'b0;
         swid_ff        <= '0;
         rsp_v_ff       <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vt_ff      <= vt_in;
         run_id_ff  <= run_id_in;
         run_v_ff   <= run_v_in;
         prev_id_ff <= prev_id_in;
         prev_v_ff  <= prev_v_in;
         opaque_ff  <= opaque_in;
         pre_ff     <= pre_in;
         chk_ff     <= chk_in;
         swp_ff     <= swp_in;
         swid_ff    <= swid_in;
         rsp_v_ff   <= rsp_v_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SLICE_TICKS: slice_ticks_ff <= csr_data[TICK_BITS-1:0];
               default:         factor_ff      <= csr_data[FACTOR_BITS-1:0];
            endcase
         end
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      tid_ff      <= tid_in;
      elap_ff     <= elap_in;
      iv_ff       <= iv_in;
      queued_ff   <= queued_in;
      force_ff    <= force_in;
      switched_ff <= switched_in;
      fast_ff     <= fast_in;
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      bestdl_ff   <= bestdl_in;
      stop_ff     <= stop_in;
      tmp_ff      <= tmp_in;
      o_task_ff   <= o_task_in;
      o_runv_ff   <= o_runv_in;
      o_queued_ff <= o_queued_in;
      o_force_ff  <= o_force_in;
      o_pre_ff    <= o_pre_in;
      o_chk_ff    <= o_chk_in;
      o_sw_ff     <= o_sw_in;
      o_cnt_ff    <= o_cnt_in;
   end

   assign rsp_valid         = rsp_v_ff;
   assign rsp_run_task      = o_task_ff;
   assign rsp_run_valid     = o_runv_ff;
   assign rsp_queued        = o_queued_ff;
   assign rsp_force_switch  = o_force_ff;
   assign rsp_preempt_flag  = o_pre_ff;
   assign rsp_check_flag    = o_chk_ff;
   assign rsp_switched      = o_sw_ff;
   assign rsp_waiting_count = o_cnt_ff;

   // With no grant the grant number rests at zero.
   a_idle_grant: assert property (@(posedge clock) disable iff (reset)
      !run_v_ff |-> run_id_ff == '0)
      else $error("grant number set without a grant");

   // A new result word only appears out of the final step.
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the final step");

   // The final step hands off and returns to idle once the output is free.
   a_done_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (state_ff == ST_IDLE && rsp_v_ff))
      else $error("final step did not hand off its word");

endmodule

// ===== verif/deadline_run_queue_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_run_queue_scheduler_checker: result predictor and scoreboard
// Watches the request, result and register channels of the scheduler, keeps
// its own copy of the task tables and run queue, predicts one result word per
// accepted request word and compares every returned word field by field.
// ----------------------------------------------------------------------------
module deadline_run_queue_scheduler_checker import drq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [ACT_BITS-1:0]      req_action,
   input  logic [TASK_BITS-1:0]     req_task_id,
   input  logic [ELAPSED_BITS-1:0]  req_elapsed,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [TASK_BITS-1:0]     rsp_run_task,
   input  logic                     rsp_run_valid,
   input  logic                     rsp_queued,
   input  logic                     rsp_force_switch,
   input  logic                     rsp_preempt_flag,
   input  logic                     rsp_check_flag,
   input  logic                     rsp_switched,
   input  logic [CNT_BITS-1:0]      rsp_waiting_count,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       fail_count,
   output int                       words_pending,
   output int                       words_checked
);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   typedef struct packed {
      logic [TASK_BITS-1:0] run_task;
      logic                 run_valid;
      logic                 queued;
      logic                 force_switch;
      logic                 preempt_flag;
      logic                 check_flag;
      logic                 switched;
      logic [CNT_BITS-1:0]  waiting_count;
   } sched_result_t;

   // Shadow copy of the scheduler state.
   logic [TICK_BITS-1:0]   cfg_slice;
   logic [FACTOR_BITS-1:0] cfg_factor;
   int                     slice_left [NUM_TASKS];
   logic [TIME_BITS-1:0]   deadline   [NUM_TASKS];
   logic [TASK_BITS-1:0]   run_queue  [NUM_TASKS];
   int                     queue_len;
   logic [TIME_BITS-1:0]   vtime;
   logic [TASK_BITS-1:0]   grant_id;
   logic                   grant_valid;
   logic [TASK_BITS-1:0]   prev_id;
   logic                   prev_valid;
   logic                   opaque;
   logic                   preempt_req;
   logic                   check_req;
   logic                   switch_req;
   logic [TASK_BITS-1:0]   switch_task;

   sched_result_t expected_words [$];

   function automatic logic [TIME_BITS-1:0] time_add(logic [TIME_BITS-1:0] a,
                                                     logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
   endfunction

   function automatic int charge(logic [ELAPSED_BITS-1:0] elapsed);
      return (elapsed < cfg_slice) ? int'(elapsed) : int'(cfg_slice);
   endfunction

   function automatic int queue_pos(logic [TASK_BITS-1:0] t);
      for (int i = 0; i < queue_len; i++)
         if (run_queue[i] == t) return i;
      return -1;
   endfunction

   function automatic void queue_drop(int idx);
      for (int i = idx; i + 1 < queue_len; i++) run_queue[i] = run_queue[i+1];
      queue_len--;
   endfunction

   function automatic void grant_to(logic [TASK_BITS-1:0] t);
      grant_id    = t;
      grant_valid = 1'b1;
      prev_valid  = 1'b0;
      switch_req  = 1'b0;
   endfunction

   // Schedule request; returns 1 when the task lands in the run queue.
   function automatic logic schedule_task(logic [TASK_BITS-1:0] t);
      logic urgent;
      if (grant_valid && grant_id == t) begin
         grant_to(t);
         return 1'b0;
      end
      if (queue_pos(t) >= 0) return 1'b0;
      if (slice_left[t] <= 0) begin
         slice_left[t] = int'(cfg_slice);
         deadline[t]   = time_add(vtime, TIME_BITS'(cfg_slice) * TIME_BITS'(cfg_factor));
      end
      if (!grant_valid) begin
         grant_to(t);
         return 1'b0;
      end
      urgent = !opaque && deadline[t] <= deadline[grant_id] &&
               deadline[grant_id] >= vtime;
      if (urgent && prev_valid) begin
         // Snatch: the displaced holder goes back to the queue head.
         for (int i = queue_len; i > 0; i--) run_queue[i] = run_queue[i-1];
         run_queue[0] = grant_id;
         queue_len++;
         grant_to(t);
         return 1'b0;
      end
      if (urgent) preempt_req = 1'b1;
      else check_req = 1'b1;
      run_queue[queue_len] = t;
      queue_len++;
      return 1'b1;
   endfunction

   // Yield; returns 1 on a force switch.
   function automatic logic yield_task(logic [TASK_BITS-1:0] t, logic fast,
                                       logic [ELAPSED_BITS-1:0] elapsed);
      logic             force_sw;
      int               best;
      int               s;
      logic [TASK_BITS-1:0] nxt;
      force_sw = 1'b0;
      if (!opaque) begin
         s = slice_left[t] - charge(elapsed);
         vtime = time_add(vtime, TIME_BITS'(charge(elapsed)));
         slice_left[t] = (s < -131072) ? -131072 : s;
      end
      preempt_req = 1'b0;
      check_req   = 1'b0;
      prev_valid  = 1'b0;
      switch_req  = 1'b0;
      if (!opaque && fast) begin
         prev_id    = t;
         prev_valid = 1'b1;
      end
      if (queue_len == 0) begin
         grant_valid = 1'b0;
         grant_id    = '0;
      end else begin
         // Earliest deadline wins, but an expired one stops the scan.
         best = 0;
         for (int i = 1; i < queue_len && deadline[run_queue[best]] > vtime; i++)
            if (deadline[run_queue[i]] < deadline[run_queue[best]]) best = i;
         nxt = run_queue[best];
         queue_drop(best);
         grant_id    = nxt;
         grant_valid = 1'b1;
         if (!opaque && (slice_left[t] <= 0 || deadline[nxt] < vtime ||
                         deadline[t] >= deadline[nxt])) begin
            switch_req  = 1'b1;
            switch_task = t;
            force_sw    = 1'b1;
         end
      end
      opaque = 1'b0;
      return force_sw;
   endfunction

   function automatic sched_result_t predict_word(logic [ACT_BITS-1:0] act,
                                                  logic [TASK_BITS-1:0] t,
                                                  logic [ELAPSED_BITS-1:0] el);
      sched_result_t r;
      logic holder;
      int   idx;
      r = '0;
      holder = grant_valid && grant_id == t;
      case (act)
         ACT_SCHEDULE: r.queued = schedule_task(t);
         ACT_YIELD: begin
            if (grant_valid && (holder || opaque)) r.force_switch = yield_task(t, 1'b1, el);
         end
         ACT_CHECK: begin
            if (holder) begin
               prev_valid = 1'b0;
               switch_req = 1'b0;
               check_req  = 1'b0;
               if (preempt_req || slice_left[t] <= charge(el)) begin
                  r.force_switch = yield_task(t, 1'b0, el);
                  r.queued       = schedule_task(t);
                  r.switched     = 1'b1;
               end
            end
         end
         default: begin
            if (holder) opaque = 1'b1;
            else if (prev_valid && prev_id == t) prev_valid = 1'b0;
            if (switch_req && switch_task == t) switch_req = 1'b0;
            idx = queue_pos(t);
            if (idx >= 0) queue_drop(idx);
            slice_left[t] = 0;
            deadline[t]   = '0;
         end
      endcase
      r.run_task      = grant_valid ? grant_id : '0;
      r.run_valid     = grant_valid;
      r.preempt_flag  = preempt_req;
      r.check_flag    = check_req;
      r.waiting_count = CNT_BITS'(queue_len);
      return r;
   endfunction

   assign words_pending = expected_words.size();

   // Track the channels on each rising edge.
   always @(posedge clock) begin
      sched_result_t got, want;
      if (reset) begin
         cfg_slice   = SLICE_TICKS_RESET;
         cfg_factor  = FACTOR_RESET;
         for (int i = 0; i < NUM_TASKS; i++) begin
            slice_left[i] = 0;
            deadline[i]   = '0;
         end
         queue_len   = 0;
         vtime       = '0;
         grant_id    = '0;
         grant_valid = 1'b0;
         prev_id     = '0;
         prev_valid  = 1'b0;
         opaque      = 1'b0;
         preempt_req = 1'b0;
         check_req   = 1'b0;
         switch_req  = 1'b0;
         switch_task = '0;
         expected_words.delete();
         fail_count    = 0;
         words_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SLICE_TICKS) cfg_slice = csr_data[TICK_BITS-1:0];
            else cfg_factor = csr_data[FACTOR_BITS-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_run_task, rsp_run_valid, rsp_queued, rsp_force_switch,
                    rsp_preempt_flag, rsp_check_flag, rsp_switched, rsp_waiting_count};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected result word %h", got);
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"ERROR: word %0d mismatch: run_task %0d/%0d run_valid %0d/%0d",
                               " queued %0d/%0d force %0d/%0d preempt %0d/%0d check %0d/%0d",
                               " switched %0d/%0d waiting %0d/%0d (expected/actual)"},
                              words_checked, want.run_task, got.run_task,
                              want.run_valid, got.run_valid, want.queued, got.queued,
                              want.force_switch, got.force_switch,
                              want.preempt_flag, got.preempt_flag,
                              want.check_flag, got.check_flag,
                              want.switched, got.switched,
                              want.waiting_count, got.waiting_count);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_words.push_back(predict_word(req_action, req_task_id, req_elapsed));
      end
   end

endmodule

// ===== verif/deadline_run_queue_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_run_queue_scheduler_top_tb: scheduler testbench top
// Drives directed and random request words through several register settings
// with random idling on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
module deadline_run_queue_scheduler_top_tb;
   import drq_pkg::*;

   localparam int WORDS_PER_PHASE = 290;
   localparam int NUM_PHASES      = 6;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ACT_BITS-1:0]      req_action = ACT_SCHEDULE;
   logic [TASK_BITS-1:0]     req_task_id = '0;
   logic [ELAPSED_BITS-1:0]  req_elapsed = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [TASK_BITS-1:0]     rsp_run_task;
   logic                     rsp_run_valid;
   logic                     rsp_queued;
   logic                     rsp_force_switch;
   logic                     rsp_preempt_flag;
   logic                     rsp_check_flag;
   logic                     rsp_switched;
   logic [CNT_BITS-1:0]      rsp_waiting_count;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SLICE_TICKS;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int fail_count;
   int words_pending;
   int words_checked;
   int words_sent = 0;
   int cycle_count = 0;
   logic [TICK_BITS-1:0] cur_slice = SLICE_TICKS_RESET;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   deadline_run_queue_scheduler_top uut (.*);

   deadline_run_queue_scheduler_checker checker_i (.*);

   // Result side: random stalls, one long hold-off and one stretch without any.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= 4000 && cycle_count < 4400) rsp_stall <= 1'b1;
      else if (cycle_count >= 8000 && cycle_count < 14000) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 28);
   end

   task automatic send_word(logic [ACT_BITS-1:0] act, logic [TASK_BITS-1:0] t,
                            logic [ELAPSED_BITS-1:0] el, logic may_idle);
      if (may_idle && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_task_id <= t;
      req_elapsed <= el;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Drain every outstanding word before touching the registers.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SLICE_TICKS) cur_slice = val;
   endtask

   task automatic random_word(logic may_idle);
      logic [ACT_BITS-1:0]     act;
      logic [TASK_BITS-1:0]    t;
      logic [ELAPSED_BITS-1:0] el;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_SCHEDULE;
      else if (pick < 70) act = ACT_YIELD;
      else if (pick < 90) act = ACT_CHECK;
      else act = ACT_CLEAR;
      // A small pool of tasks keeps yields and checkpoints hitting the holder.
      t = ($urandom_range(99) < 80) ? TASK_BITS'($urandom_range(5)) : TASK_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 50) el = ELAPSED_BITS'($urandom_range(0, 2 * int'(cur_slice)));
      else if (pick < 80) el = ELAPSED_BITS'($urandom_range(0, 100));
      else el = ELAPSED_BITS'($urandom);
      send_word(act, t, el, may_idle);
   endtask

   initial begin
      logic [TICK_BITS-1:0]   slices  [NUM_PHASES];
      logic [FACTOR_BITS-1:0] factors [NUM_PHASES];
      slices  = '{16'd10000, 16'd1, 16'd65535, 16'd100, 16'd7, 16'd2500};
      factors = '{7'd8, 7'd64, 7'd1, 7'd3, 7'd64, 7'd1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: grant, queue, ignore, yields, checkpoints, snatch and clears.
      send_word(ACT_SCHEDULE, 4'd0, '0, 1'b0);
      send_word(ACT_SCHEDULE, 4'd1, '0, 1'b0);
      send_word(ACT_SCHEDULE, 4'd1, '0, 1'b0);
      send_word(ACT_SCHEDULE, 4'd2, '0, 1'b0);
      send_word(ACT_YIELD,    4'd0, '0, 1'b0);
      send_word(ACT_SCHEDULE, 4'd3, 24'd5, 1'b0);
      send_word(ACT_YIELD,    4'd1, 24'hFFFFFF, 1'b0);
      send_word(ACT_YIELD,    4'd9, 24'd1, 1'b0);
      send_word(ACT_CHECK,    4'd9, 24'd0, 1'b0);
      send_word(ACT_CHECK,    4'd3, 24'd0, 1'b0);
      send_word(ACT_CHECK,    4'd3, 24'hFFFFFF, 1'b0);
      send_word(ACT_SCHEDULE, 4'd15, 24'h555555, 1'b0);
      send_word(ACT_CLEAR,    4'd15, 24'hAAAAAA, 1'b0);
      send_word(ACT_CLEAR,    4'd1, '0, 1'b0);
      send_word(ACT_YIELD,    4'd12, 24'd300, 1'b0);
      send_word(ACT_CLEAR,    4'd2, '0, 1'b0);
      send_word(ACT_CLEAR,    4'd0, '0, 1'b0);
      send_word(ACT_YIELD,    4'd3, 24'd20000, 1'b0);
      send_word(ACT_YIELD,    4'd3, 24'd20000, 1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_csr(CSR_SLICE_TICKS, slices[p]);
         write_csr(CSR_FACTOR, CSR_DATA_BITS'(factors[p]));
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            random_word(!(p == 2 && n < 150));
      end

      wait_drained();
      $display("Summary: %0d request words over %0d register settings, %0d results checked.",
               words_sent, NUM_PHASES, words_checked);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("Timeout with %0d words outstanding.", words_pending);
      $display("Test completed with failures");
      $finish;
   end

endmodule
